@@ design/bls_pkg.sv @@
package bls_pkg;

  // Coordinate width and the width of the signed decision term.
  localparam int COORD_BITS = 9;
  localparam int DEC_BITS   = COORD_BITS + 3;

  // Depth of the queue between the front and the back (a power of two).
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Operation codes of an input beat.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic   is_load;
    coord_t start_x;
    coord_t start_y;
    coord_t major_delta;
    coord_t minor_delta;
    logic   x_negative;
    logic   y_negative;
    logic   x_is_major;
    dec_t   decision;
  } bls_entry_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic       valid;
    bls_entry_t entry;
  } bls_head_t;

endpackage

@@ design/bresenham_line_stepper.sv @@
// Bresenham line stepper.
// Input channel (in_valid/in_ready): a beat with op = load takes the two
// endpoints and sets up a new line, dropping any line in progress; it gives
// no result. A beat with op = step asks for the next pixel of the line.
// Output channel (out_valid/out_ready): one beat per step while a line is
// being walked, carrying pixel_x, pixel_y and last on the final pixel. The
// second endpoint is not drawn; a step while idle gives no beat.
// A step beat goes into the queue, then its pixel into the output register.
// Throughput is one beat per clock while out_ready is high, set by the
// single add-and-compare of the walk unit.
// Beats pass from the setup logic to the walk unit through a two-entry
// queue, so input is taken while a finished pixel waits at the output.
// When the receiver stalls, the pixel holds in the output register, the
// queue fills, and in_ready falls after two more beats.
// Reset (rst, synchronous) empties the queue and the output register and
// leaves the block idle with no line loaded.
module bresenham_line_stepper import bls_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   op,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t pixel_x,
  output coord_t pixel_y,
  output logic   last
);

  bls_entry_t front_entry;
  bls_head_t  head;
  logic       full;
  logic       pop;

  assign in_ready = !full;

  // Setup and classification of each input beat.
  bls_front u_front (
    .op      (op),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .entry   (front_entry)
  );

  // Queue between setup and walk.
  bls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !full),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .head       (head)
  );

  // Walk unit with output register.
  bls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

endmodule

@@ design/bls_front.sv @@
module bls_front import bls_pkg::*; (
  input  logic       op,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  output bls_entry_t entry
);

  logic   x_neg;
  logic   y_neg;
  coord_t dx;
  coord_t dy;
  logic   x_major;
  coord_t major;
  coord_t minor;

  // Direction and absolute delta on each axis.
  assign x_neg = end_x < start_x;
  assign y_neg = end_y < start_y;
  assign dx    = x_neg ? (start_x - end_x) : (end_x - start_x);
  assign dy    = y_neg ? (start_y - end_y) : (end_y - start_y);

  // Equal deltas leave y as the major axis.
  assign x_major = dx > dy;
  assign major   = x_major ? dx : dy;
  assign minor   = x_major ? dy : dx;

  // Pack the classified beat; the initial decision term is 2*minor - major.
  always_comb begin
    entry.is_load     = (op == OP_LOAD);
    entry.start_x     = start_x;
    entry.start_y     = start_y;
    entry.major_delta = major;
    entry.minor_delta = minor;
    entry.x_negative  = x_neg;
    entry.y_negative  = y_neg;
    entry.x_is_major  = x_major;
    entry.decision    = dec_t'({minor, 1'b0}) - dec_t'(major);
  end

endmodule

@@ design/bls_queue.sv @@
module bls_queue import bls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bls_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output bls_head_t  head
);

  bls_entry_t           entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full       = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

@@ design/bls_back.sv @@
module bls_back import bls_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  bls_head_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output coord_t    pixel_x,
  output coord_t    pixel_y,
  output logic      last
);

  // Walk state.
  coord_t cur_x;
  coord_t cur_y;
  dec_t   decision;
  coord_t major_delta;
  coord_t minor_delta;
  coord_t remaining;
  logic   x_negative;
  logic   y_negative;
  logic   x_is_major;
  logic   active;

  logic   emit;
  logic   minor_move;
  dec_t   major_ext;
  dec_t   minor_ext;
  coord_t remaining_next;

  function automatic coord_t move_coord(input coord_t c, input logic neg);
    return neg ? (c - COORD_BITS'(1)) : (c + COORD_BITS'(1));
  endfunction

  // A step beat while walking needs room in the output register; loads and
  // steps while idle leave the queue at once.
  assign emit = head.valid && !head.entry.is_load && active;
  assign pop  = head.valid && (!emit || !out_valid || out_ready);

  assign minor_move     = !decision[DEC_BITS-1];
  assign major_ext      = dec_t'(major_delta);
  assign minor_ext      = dec_t'(minor_delta);
  assign remaining_next = remaining - COORD_BITS'(1);

  // Walk registers: set up on a load, advanced on each emitted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      decision    <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      remaining   <= '0;
      x_negative  <= 1'b0;
      y_negative  <= 1'b0;
      x_is_major  <= 1'b0;
      active      <= 1'b0;
    end else if (pop && head.entry.is_load) begin
      cur_x       <= head.entry.start_x;
      cur_y       <= head.entry.start_y;
      decision    <= head.entry.decision;
      major_delta <= head.entry.major_delta;
      minor_delta <= head.entry.minor_delta;
      remaining   <= head.entry.major_delta;
      x_negative  <= head.entry.x_negative;
      y_negative  <= head.entry.y_negative;
      x_is_major  <= head.entry.x_is_major;
      active      <= (head.entry.major_delta != '0);
    end else if (pop && emit) begin
      if (x_is_major || minor_move) begin
        cur_x <= move_coord(cur_x, x_negative);
      end
      if (!x_is_major || minor_move) begin
        cur_y <= move_coord(cur_y, y_negative);
      end
      if (minor_move) begin
        decision <= decision + ((minor_ext - major_ext) <<< 1);
      end else begin
        decision <= decision + (minor_ext <<< 1);
      end
      remaining <= remaining_next;
      active    <= (remaining_next != '0);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      pixel_x <= cur_x;
      pixel_y <= cur_y;
      last    <= (remaining == COORD_BITS'(1));
    end
  end

`ifndef SYNTHESIS
  // The active flag always tracks a non-zero pixel count.
  a_active_count: assert property (@(posedge clk) disable iff (rst)
    active == (remaining != '0))
    else $error("active flag disagrees with the pixel count");

  // An emitted pixel is held in the output register in the next cycle.
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (pop && emit) |=> out_valid)
    else $error("emitted pixel lost");

  // A pending result blocks a step beat until it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && emit) |-> !pop)
    else $error("pending pixel overwritten");

  // The last pixel of a line leaves the block idle.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && emit && remaining == COORD_BITS'(1)) |=> !active)
    else $error("walk continues past the last pixel");
`endif

endmodule

@@ sim/bresenham_line_stepper_test.sv @@
module bresenham_line_stepper_test import bls_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1400;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int MAX_REPORTS = 10;

  // One pixel as it should leave the output channel.
  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Tracks the line walk beat by beat and holds the pixels still owed.
  class pixel_tracker;
    coord_t cur_x       = '0;
    coord_t cur_y       = '0;
    dec_t   decision    = '0;
    coord_t major_d     = '0;
    coord_t minor_d     = '0;
    coord_t remaining   = '0;
    logic   x_neg       = 1'b0;
    logic   y_neg       = 1'b0;
    logic   x_major     = 1'b0;
    logic   active      = 1'b0;
    pixel_t pending_pixels[$];
    int     errors      = 0;
    int     lines       = 0;
    int     pixels      = 0;
    int     line_ends   = 0;
    int     idle_steps  = 0;

    function void note_error(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ns: %s", $realtime, msg);
      end
    endfunction

    // Advance the walk for one accepted input beat.
    function void take_beat(logic op_i, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      coord_t dx;
      coord_t dy;
      pixel_t px;
      if (op_i == OP_LOAD) begin
        x_neg     = ex < sx;
        y_neg     = ey < sy;
        dx        = x_neg ? coord_t'(sx - ex) : coord_t'(ex - sx);
        dy        = y_neg ? coord_t'(sy - ey) : coord_t'(ey - sy);
        x_major   = dx > dy;
        major_d   = x_major ? dx : dy;
        minor_d   = x_major ? dy : dx;
        decision  = dec_t'(2 * int'(minor_d) - int'(major_d));
        cur_x     = sx;
        cur_y     = sy;
        remaining = major_d;
        active    = remaining != '0;
        lines++;
      end else if (!active) begin
        idle_steps++;
      end else begin
        px.x    = cur_x;
        px.y    = cur_y;
        px.last = remaining == coord_t'(1);
        pending_pixels.push_back(px);
        // A non-negative decision term moves the minor axis as well.
        if (decision >= 0) begin
          if (x_major) begin
            cur_y = y_neg ? coord_t'(cur_y - 1'b1) : coord_t'(cur_y + 1'b1);
          end else begin
            cur_x = x_neg ? coord_t'(cur_x - 1'b1) : coord_t'(cur_x + 1'b1);
          end
          decision = dec_t'(int'(decision) + 2 * (int'(minor_d) - int'(major_d)));
        end else begin
          decision = dec_t'(int'(decision) + 2 * int'(minor_d));
        end
        if (x_major) begin
          cur_x = x_neg ? coord_t'(cur_x - 1'b1) : coord_t'(cur_x + 1'b1);
        end else begin
          cur_y = y_neg ? coord_t'(cur_y - 1'b1) : coord_t'(cur_y + 1'b1);
        end
        remaining = coord_t'(remaining - 1'b1);
        active    = remaining != '0;
      end
    endfunction

    // Compare an output beat with the oldest pixel owed.
    function void match_pixel(coord_t px_x, coord_t px_y, logic px_last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        note_error($sformatf("unexpected pixel (%0d,%0d) last=%0b", px_x, px_y, px_last));
        return;
      end
      want = pending_pixels.pop_front();
      pixels++;
      if (px_last) begin
        line_ends++;
      end
      if (px_x !== want.x || px_y !== want.y || px_last !== want.last) begin
        note_error($sformatf("pixel mismatch: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                             want.x, want.y, want.last, px_x, px_y, px_last));
      end
    endfunction
  endclass

  logic   clk       = 1'b0;
  logic   rst       = 1'b1;
  logic   in_valid  = 1'b0;
  logic   in_ready;
  logic   op        = OP_LOAD;
  coord_t start_x   = '0;
  coord_t start_y   = '0;
  coord_t end_x     = '0;
  coord_t end_y     = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last;

  pixel_tracker tracker = new;
  logic in_calm    = 1'b0;
  logic out_calm   = 1'b0;
  int   work_beats = 0;

  bresenham_line_stepper uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pick_pause(logic calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(11, 40);
  endfunction

  // A coordinate within span of c, clamped to the coordinate range.
  function automatic coord_t nearby(coord_t c, int span);
    int r;
    int v;
    r = $urandom_range(0, 2 * span);
    v = int'(c) + r - span;
    if (v < 0) begin
      v = 0;
    end
    if (v > COORD_MAX) begin
      v = COORD_MAX;
    end
    return coord_t'(v);
  endfunction

  // Drive one input beat after a random pause and wait for its handshake.
  task automatic send_beat(logic o, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int pause;
    pause = pick_pause(in_calm);
    if (pause > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (pause - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op       = o;
    start_x  = sx;
    start_y  = sy;
    end_x    = ex;
    end_y    = ey;
    do @(posedge clk); while (!in_ready);
    tracker.take_beat(o, sx, sy, ex, ey);
  endtask

  task automatic load_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    work_beats++;
    send_beat(OP_LOAD, sx, sy, ex, ey);
  endtask

  // A step beat carries junk in the coordinate fields; the block ignores them.
  task automatic step_line(int count);
    for (int i = 0; i < count; i++) begin
      if (tracker.active) begin
        work_beats++;
      end
      send_beat(OP_STEP,
                coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)),
                coord_t'($urandom_range(0, COORD_MAX)));
    end
  endtask

  // Receiver side: runs of ready broken by stalls of random length.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!out_calm && $urandom_range(0, 99) < 15) begin
          hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  // Check every output beat at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.match_pixel(pixel_x, pixel_y, last);
    end
  end

  initial begin
    int     shape;
    int     n;
    int     waited;
    logic   far_line;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: idle step, zero-length line, axis-aligned lines in the
    // negative direction, equal deltas, a reload mid-line and the corners.
    step_line(1);
    load_line(9'd0, 9'd0, 9'd0, 9'd0);
    step_line(1);
    load_line(9'd9, 9'd3, 9'd5, 9'd3);
    step_line(5);
    load_line(9'd2, 9'd9, 9'd2, 9'd6);
    step_line(3);
    load_line(9'd511, 9'd0, 9'd508, 9'd3);
    step_line(1);
    load_line(9'd511, 9'd511, 9'd0, 9'd0);
    step_line(2);
    load_line(9'd0, 9'd0, 9'd511, 9'd200);
    step_line(2);
    load_line(9'd0, 9'd511, 9'd7, 9'd510);
    step_line(2);

    // Random part: mostly whole short lines, some cut short by a new load,
    // a few long ones, and stray steps between lines.
    while (work_beats < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        in_calm = !in_calm;
      end
      if ($urandom_range(0, 19) == 0) begin
        out_calm = !out_calm;
      end
      if ($urandom_range(0, 99) < 4) begin
        step_line(1);
        continue;
      end
      sx       = coord_t'($urandom_range(0, COORD_MAX));
      sy       = coord_t'($urandom_range(0, COORD_MAX));
      far_line = 1'b0;
      shape    = $urandom_range(0, 99);
      if (shape < 60) begin
        ex = nearby(sx, 12);
        ey = nearby(sy, 12);
      end else if (shape < 80) begin
        ex = nearby(sx, 90);
        ey = nearby(sy, 90);
      end else if (shape < 85) begin
        ex = sx;
        ey = sy;
      end else if (shape < 92) begin
        if ($urandom_range(0, 1) == 0) begin
          ex = sx;
          ey = nearby(sy, 30);
        end else begin
          ex = nearby(sx, 30);
          ey = sy;
        end
      end else begin
        ex       = coord_t'($urandom_range(0, COORD_MAX));
        ey       = coord_t'($urandom_range(0, COORD_MAX));
        far_line = 1'b1;
      end
      load_line(sx, sy, ex, ey);
      n = int'(tracker.remaining);
      if ($urandom_range(0, 3) == 0 || (far_line && $urandom_range(0, 9) != 0)) begin
        n = $urandom_range(0, n);
      end else if ($urandom_range(0, 4) == 0) begin
        n += $urandom_range(1, 2);
      end
      step_line(n);
    end

    @(negedge clk);
    in_valid = 1'b0;

    // Drain the pixels still owed, then watch for strays.
    waited = 0;
    while (tracker.pending_pixels.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (tracker.pending_pixels.size() != 0) begin
      tracker.note_error($sformatf("%0d pixels never arrived", tracker.pending_pixels.size()));
    end

    $display("Loaded %0d lines, checked %0d pixels over %0d completed lines,",
             tracker.lines, tracker.pixels, tracker.line_ends);
    $display("sent %0d steps to an idle block, and saw %0d mismatches.",
             tracker.idle_steps, tracker.errors);
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
